/* design/ect_pkg.sv */
// Shared types and constants of the ear clipping triangulator.
// No dependencies; ect_if and the triangulator top use this package.
package ect_pkg;

  localparam int MAX_VERTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_BITS       = 6;
  localparam int STATUS_BITS    = 2;

  localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_NO_EAR   = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_TOO_FEW  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STAT_TOO_MANY = 2'd3;

  typedef enum logic [4:0] {
    S_LOAD,
    S_CHECK,
    S_WIND,
    S_SETW,
    S_LINK,
    S_TOP,
    S_V_GET,
    S_P_GET,
    S_N_GET,
    S_CONV_M,
    S_CONV_E,
    S_W_TOP,
    S_W_GET,
    S_TRI,
    S_ADV,
    S_CLIP,
    S_F_GET,
    S_EMIT
  } state_t;

endpackage

/* design/ect_if.sv */
// Valid/ready channel interfaces for vertex input and triangle output.
// Depends on ect_pkg for index and status widths.
interface ect_vertex_if #(
  parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_vertex;

  modport source (output valid, x_coord, y_coord, last_vertex, input ready);
  modport sink   (input valid, x_coord, y_coord, last_vertex, output ready);
endinterface

interface ect_triangle_if;
  logic                                 valid;
  logic                                 ready;
  logic [ect_pkg::IDX_BITS-1:0]         previous_index;
  logic [ect_pkg::IDX_BITS-1:0]         ear_index;
  logic [ect_pkg::IDX_BITS-1:0]         next_index;
  logic [ect_pkg::STATUS_BITS-1:0]      status;
  logic                                 last_triangle;

  modport source (output valid, previous_index, ear_index, next_index, status,
                  last_triangle, input ready);
  modport sink   (input valid, previous_index, ear_index, next_index, status,
                  last_triangle, output ready);
endinterface

/* design/ect_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/ear_clipping_triangulator_top.sv */
// Ear clipping triangulator: loads one vertex per cycle while in the load state; one polygon at a time.
// After the last vertex: winding setup, then link setup of each vertex in turn. Corner test
// of the candidate, then an advance past a reflex corner. Ear test against each remaining
// vertex, with the corners of the candidate skipped, then an advance or a clip and emit;
// then the final triangle. Error results go straight to emit after the last vertex; output
// stalls hold the emit. Synchronous reset clears control state; RAMs undefined.
module ear_clipping_triangulator_top #(
  parameter int MAX_VERTS  = ect_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = ect_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  ect_vertex_if.sink     vertex_in,
  ect_triangle_if.source triangle_out
);
  import ect_pkg::*;

  localparam int IW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW    = $clog2(MAX_VERTS + 1);
  localparam int CB    = COORD_BITS;
  localparam int PW    = 2 * CB + 2;
  localparam int SUM_W = CW + 2 * CB + 3;

  state_t state, state_next;

  logic [CW-1:0]  cnt, lcnt, rem, it;
  logic           ovf, cw, pend, pend_next;
  logic signed [SUM_W-1:0] sum;
  logic signed [PW-1:0]    prod;
  logic signed [CB-1:0]    lx, ly, fx, fy;
  logic signed [CB-1:0]    xv, yv, xp, yp, xn, yn, xw, yw;
  logic [IW-1:0]  head, scan, lap, v, p, n, w;
  logic [1:0]     ph;
  logic           s0, s1;
  logic signed [PW-1:0]    pa, pb;
  logic [IW-1:0]  e_p, e_e, e_n;
  logic [STATUS_BITS-1:0] e_st;
  logic           e_last;
  logic           ov;

  // RAM ports
  logic                 xy_we, nl_we, pl_we;
  logic [IW-1:0]        xy_waddr, nl_waddr, pl_waddr;
  logic [IW-1:0]        xy_raddr, nl_raddr, pl_raddr;
  logic [2*CB-1:0]      xy_wdata, xy_rdata;
  logic [IW-1:0]        nl_wdata, pl_wdata, nl_rdata, pl_rdata;

  ect_ram #(.WIDTH(2*CB), .DEPTH(MAX_VERTS)) u_xy_ram (
    .clk(clk), .we(xy_we), .waddr(xy_waddr), .wdata(xy_wdata),
    .raddr(xy_raddr), .rdata(xy_rdata)
  );
  ect_ram #(.WIDTH(IW), .DEPTH(MAX_VERTS)) u_next_ram (
    .clk(clk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
    .raddr(nl_raddr), .rdata(nl_rdata)
  );
  ect_ram #(.WIDTH(IW), .DEPTH(MAX_VERTS)) u_prev_ram (
    .clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
    .raddr(pl_raddr), .rdata(pl_rdata)
  );

  logic signed [CB-1:0] rx, ry;
  assign rx = xy_rdata[CB-1:0];
  assign ry = xy_rdata[2*CB-1:CB];

  logic acc, room, slot_free;
  assign vertex_in.ready = (state == S_LOAD) && !rst;
  assign acc       = vertex_in.valid && vertex_in.ready;
  assign room      = (cnt < CW'(MAX_VERTS));
  assign slot_free = !ov || triangle_out.ready;

  // edge sum operands, one bit wider than a coordinate
  logic signed [CB:0] ld_sx, ld_dy, cl_sx, cl_dy;
  assign ld_sx = lx + vertex_in.x_coord;
  assign ld_dy = ly - vertex_in.y_coord;
  assign cl_sx = lx + fx;
  assign cl_dy = ly - fy;

  assign pend_next = (state == S_LOAD && acc && room && cnt != '0) ||
                     (state == S_CHECK && !(ovf || cnt < CW'(3)));

  // cross product operands
  logic signed [CB-1:0] t1x, t1y, t2x, t2y, t3x, t3y;
  logic signed [CB:0]   d1, d2, d3, d4;
  logic signed [PW:0]   diff;
  logic                 neg, side_pos, convex, in_tri, skip;

  always_comb begin
    t1x = xw; t1y = yw;
    t2x = xp; t2y = yp;
    t3x = xv; t3y = yv;
    unique case (ph)
      2'd1:    begin t2x = xv; t2y = yv; t3x = xn; t3y = yn; end
      2'd2:    begin t2x = xn; t2y = yn; t3x = xp; t3y = yp; end
      default: begin end
    endcase
    if (state == S_CONV_M) begin
      d1 = xn - xp;
      d2 = yv - yp;
      d3 = yn - yp;
      d4 = xv - xp;
    end else begin
      d1 = t1x - t3x;
      d2 = t2y - t3y;
      d3 = t2x - t3x;
      d4 = t1y - t3y;
    end
  end

  assign diff     = pa - pb;
  assign neg      = diff[PW];
  assign side_pos = !neg && (diff != '0);
  assign convex   = !((!cw && side_pos) || (cw && neg));
  assign in_tri   = (s0 == s1) && (s1 == neg);
  assign skip     = (w == v) || (w == p) || (w == n);

  // link setup values
  logic [CW-1:0] cnt_m1, lnext, lprev;
  assign cnt_m1 = cnt - 1'b1;
  assign lnext  = (lcnt == cnt_m1) ? '0 : lcnt + 1'b1;
  assign lprev  = (lcnt == '0) ? cnt_m1 : lcnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    xy_we = 1'b0; nl_we = 1'b0; pl_we = 1'b0;
    xy_waddr = cnt[IW-1:0];
    xy_wdata = {vertex_in.y_coord, vertex_in.x_coord};
    nl_waddr = lcnt[IW-1:0]; nl_wdata = lnext[IW-1:0];
    pl_waddr = lcnt[IW-1:0]; pl_wdata = lprev[IW-1:0];
    xy_raddr = scan; nl_raddr = scan; pl_raddr = scan;
    unique case (state)
      S_LOAD: begin
        xy_we = acc && room;
        if (acc && vertex_in.last_vertex) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (ovf || cnt < CW'(3)) state_next = S_EMIT;
        else                     state_next = S_WIND;
      end
      S_WIND: state_next = S_SETW;
      S_SETW: state_next = S_LINK;
      S_LINK: begin
        nl_we = 1'b1;
        pl_we = 1'b1;
        if (lcnt == cnt_m1) state_next = S_TOP;
      end
      S_TOP: begin
        if (rem > CW'(3)) begin
          state_next = S_V_GET;
        end else begin
          nl_raddr   = head;
          pl_raddr   = head;
          state_next = S_F_GET;
        end
      end
      S_V_GET: begin
        xy_raddr   = pl_rdata;
        state_next = S_P_GET;
      end
      S_P_GET: begin
        xy_raddr   = n;
        state_next = S_N_GET;
      end
      S_N_GET:  state_next = S_CONV_M;
      S_CONV_M: state_next = S_CONV_E;
      S_CONV_E: state_next = convex ? S_W_TOP : S_ADV;
      S_W_TOP: begin
        xy_raddr = w;
        nl_raddr = w;
        state_next = (it == rem) ? S_CLIP : S_W_GET;
      end
      S_W_GET: state_next = skip ? S_W_TOP : S_TRI;
      S_TRI: begin
        if (ph == 2'd3) state_next = in_tri ? S_ADV : S_W_TOP;
      end
      S_ADV: state_next = (n == lap) ? S_EMIT : S_TOP;
      S_CLIP: begin
        nl_we = 1'b1; nl_waddr = p; nl_wdata = n;
        pl_we = 1'b1; pl_waddr = n; pl_wdata = p;
        state_next = S_EMIT;
      end
      S_F_GET: state_next = S_EMIT;
      S_EMIT: begin
        if (slot_free) state_next = e_last ? S_LOAD : S_TOP;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= pend_next;
    end
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      sum  <= '0;
      ovf  <= 1'b0;
      cw   <= 1'b0;
      head <= '0;
      scan <= '0;
      lap  <= '0;
    end else begin
      if (pend) sum <= sum + SUM_W'(prod);
      unique case (state)
        S_LOAD: begin
          if (acc) begin
            if (room) begin
              if (cnt == '0) begin
                fx <= vertex_in.x_coord;
                fy <= vertex_in.y_coord;
              end else begin
                prod <= ld_sx * ld_dy;
              end
              lx  <= vertex_in.x_coord;
              ly  <= vertex_in.y_coord;
              cnt <= cnt + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        S_CHECK: begin
          e_p <= '0; e_e <= '0; e_n <= '0; e_last <= 1'b1;
          e_st <= ovf ? STAT_TOO_MANY : STAT_TOO_FEW;
          prod <= cl_sx * cl_dy;
        end
        S_SETW: begin
          cw   <= (sum >= 0);
          lcnt <= '0;
        end
        S_LINK: begin
          lcnt <= lcnt + 1'b1;
          head <= '0; scan <= '0; lap <= '0;
          rem  <= cnt;
        end
        S_TOP: v <= scan;
        S_V_GET: begin
          p <= pl_rdata; n <= nl_rdata;
          xv <= rx; yv <= ry;
        end
        S_P_GET: begin xp <= rx; yp <= ry; end
        S_N_GET: begin xn <= rx; yn <= ry; end
        S_CONV_M: begin
          pa <= d1 * d2;
          pb <= d3 * d4;
        end
        S_CONV_E: begin
          w  <= head;
          it <= '0;
        end
        S_W_GET: begin
          xw <= rx; yw <= ry;
          w  <= nl_rdata;
          ph <= 2'd0;
          if (skip) it <= it + 1'b1;
        end
        S_TRI: begin
          pa <= d1 * d2;
          pb <= d3 * d4;
          ph <= ph + 1'b1;
          if (ph == 2'd1) s0 <= neg;
          if (ph == 2'd2) s1 <= neg;
          if (ph == 2'd3) it <= it + 1'b1;
        end
        S_ADV: begin
          scan <= n;
          e_p <= '0; e_e <= '0; e_n <= '0;
          e_st <= STAT_NO_EAR; e_last <= 1'b1;
        end
        S_CLIP: begin
          e_p <= p; e_e <= v; e_n <= n;
          e_st <= STAT_OK; e_last <= 1'b0;
          if (v == head) head <= n;
          rem  <= rem - 1'b1;
          scan <= p;
          lap  <= p;
        end
        S_F_GET: begin
          e_p <= pl_rdata; e_e <= head; e_n <= nl_rdata;
          e_st <= STAT_OK; e_last <= 1'b1;
        end
        S_EMIT: begin
          if (slot_free) begin
            triangle_out.previous_index <= IDX_BITS'(e_p);
            triangle_out.ear_index      <= IDX_BITS'(e_e);
            triangle_out.next_index     <= IDX_BITS'(e_n);
            triangle_out.status         <= e_st;
            triangle_out.last_triangle  <= e_last;
            if (e_last) begin
              cnt <= '0;
              sum <= '0;
              ovf <= 1'b0;
            end
          end
        end
        default: begin end
      endcase
    end
  end

  // output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (state == S_EMIT && slot_free) begin
      ov <= 1'b1;
    end else if (triangle_out.ready) begin
      ov <= 1'b0;
    end
  end

  assign triangle_out.valid = ov;

endmodule

/* tb/sv/tb_ear_clipping_triangulator_top.sv */
// Self-checking testbench for the ear clipping triangulator.
// Depends on ect_pkg, ect_if and the ear_clipping_triangulator_top RTL.
module tb_ear_clipping_triangulator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ect_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } vertex_t;

  typedef struct packed {
    logic [5:0] prv;
    logic [5:0] ear;
    logic [5:0] nxt;
    logic [1:0] st;
    logic       fin;
  } tri_t;

  logic clk;
  logic rst;

  ect_vertex_if   vin();
  ect_triangle_if tout();

  ear_clipping_triangulator_top dut (
    .clk(clk), .rst(rst), .vertex_in(vin.sink), .triangle_out(tout.source)
  );

  vertex_t vertex_q[$];
  tri_t    tri_q[$];
  int      errors;
  bit      hold_send;
  bit      in_flight;

  // predictor state
  longint px[64];
  longint py[64];
  int     nl[64];
  int     pl[64];
  int     n_loaded;
  longint area_sum;
  bit     overflow;

  task automatic report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic longint cross3(int a, int b, int c);
    return (px[a] - px[c]) * (py[b] - py[c]) - (px[b] - px[c]) * (py[a] - py[c]);
  endfunction

  function automatic bit point_in(int w, int a, int b, int c);
    bit s1, s2, s3;
    s1 = cross3(w, a, b) < 0;
    s2 = cross3(w, b, c) < 0;
    s3 = cross3(w, c, a) < 0;
    return (s1 == s2) && (s2 == s3);
  endfunction

  function automatic tri_t mk(int p, int e, int n, logic [1:0] s, bit f);
    tri_t t;
    t.prv = 6'(p); t.ear = 6'(e); t.nxt = 6'(n); t.st = s; t.fin = f;
    return t;
  endfunction

  task automatic triangulate(vertex_t v);
    int rem, head, scan, lap, vv, p, n, w, i;
    bit cw, ok;
    longint side;
    if (n_loaded < 64) begin
      px[n_loaded] = v.x;
      py[n_loaded] = v.y;
      if (n_loaded > 0)
        area_sum += (px[n_loaded-1] + v.x) * (py[n_loaded-1] - v.y);
      n_loaded++;
    end else begin
      overflow = 1;
    end
    if (!v.last) return;
    if (overflow) begin
      tri_q = {tri_q, mk(0, 0, 0, STAT_TOO_MANY, 1'b1)};
    end else if (n_loaded < 3) begin
      tri_q = {tri_q, mk(0, 0, 0, STAT_TOO_FEW, 1'b1)};
    end else begin
      rem = n_loaded;
      area_sum += (px[rem-1] + px[0]) * (py[rem-1] - py[0]);
      cw = area_sum >= 0;
      for (i = 0; i < rem; i++) begin
        nl[i] = (i + 1) % rem;
        pl[i] = (i + rem - 1) % rem;
      end
      head = 0; scan = 0; lap = 0;
      while (rem > 3) begin
        vv = scan; p = pl[vv]; n = nl[vv];
        side = (px[n] - px[p]) * (py[vv] - py[p]) - (py[n] - py[p]) * (px[vv] - px[p]);
        ok = !((!cw && side > 0) || (cw && side < 0));
        if (ok) begin
          w = head;
          for (i = 0; i < rem; i++) begin
            if (w != vv && w != p && w != n && point_in(w, p, vv, n)) ok = 0;
            w = nl[w];
          end
        end
        if (ok) begin
          tri_q = {tri_q, mk(p, vv, n, STAT_OK, 1'b0)};
          nl[p] = n; pl[n] = p;
          if (vv == head) head = n;
          rem--; scan = p; lap = p;
        end else begin
          scan = nl[vv];
          if (scan == lap) begin
            tri_q = {tri_q, mk(0, 0, 0, STAT_NO_EAR, 1'b1)};
            rem = 0;
          end
        end
      end
      if (rem == 3) tri_q = {tri_q, mk(pl[head], head, nl[head], STAT_OK, 1'b1)};
    end
    n_loaded = 0; area_sum = 0; overflow = 0;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // sender
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      vin.valid <= 0; vin.x_coord <= 0; vin.y_coord <= 0; vin.last_vertex <= 0;
      send_gap <= 0;
    end else if (!vin.valid || vin.ready) begin
      if (vin.valid) triangulate({vin.x_coord, vin.y_coord, vin.last_vertex});
      if (send_gap > 0 || hold_send || vertex_q.size() == 0) begin
        vin.valid <= 0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        vertex_t v;
        v = vertex_q.pop_front();
        vin.valid <= 1; vin.x_coord <= v.x; vin.y_coord <= v.y;
        vin.last_vertex <= v.last;
        send_gap <= gap_len();
      end
    end
  end
  assign in_flight = vin.valid;

  // receiver
  int recv_gap;
  always @(posedge clk) begin
    if (rst) begin
      tout.ready <= 0; recv_gap <= 0;
    end else begin
      if (tout.valid && tout.ready) begin
        tri_t got, want;
        got = mk(tout.previous_index, tout.ear_index, tout.next_index, tout.status,
                 tout.last_triangle);
        if (tri_q.size() == 0) begin
          report($sformatf("unexpected result %h", got));
        end else begin
          want = tri_q.pop_front();
          if (got.prv != want.prv) report($sformatf("previous %0d/%0d", got.prv, want.prv));
          if (got.ear != want.ear) report($sformatf("ear %0d/%0d", got.ear, want.ear));
          if (got.nxt != want.nxt) report($sformatf("next %0d/%0d", got.nxt, want.nxt));
          if (got.st != want.st) report($sformatf("status %0d/%0d", got.st, want.st));
          if (got.fin != want.fin) report($sformatf("last %0d/%0d", got.fin, want.fin));
        end
      end
      if (recv_gap > 0) begin
        tout.ready <= 0; recv_gap <= recv_gap - 1;
      end else begin
        tout.ready <= 1; recv_gap <= gap_len();
      end
    end
  end

  task automatic add(int x, int y, bit l);
    vertex_t v;
    v.x = 16'(x); v.y = 16'(y); v.last = l;
    vertex_q = {vertex_q, v};
  endtask

  // regular-ish polygon with jittered radius; noise adds reflex corners
  task automatic add_poly(int n, int r, bit rev);
    int i, k, rr;
    real a;
    for (i = 0; i < n; i++) begin
      k = rev ? n - 1 - i : i;
      a = 6.2831853 * k / n;
      rr = r - $urandom_range(0, r / 2);
      add($rtoi(rr * $cos(a)), $rtoi(rr * $sin(a)), i == n - 1);
    end
  endtask

  int i, n, sent;
  initial begin
    rst = 1; hold_send = 0; errors = 0;
    n_loaded = 0; area_sum = 0; overflow = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    // directed
    add(-32768, -32768, 0); add(32767, -32768, 0); add(0, 32767, 1);
    add(-32768, 32767, 0); add(32767, 32767, 0); add(0, -32768, 1);
    add(5, 5, 1);
    add(1, 2, 0); add(3, 4, 1);
    add(0, 0, 0); add(10, 0, 0); add(10, 10, 0); add(0, 10, 1);
    add(0, 0, 0); add(4, 0, 0); add(8, 0, 0); add(4, 4, 1);
    add(0, 0, 0); add(0, 0, 0); add(0, 0, 0); add(0, 0, 1);
    add(0, 0, 0); add(10, 0, 0); add(5, 5, 0); add(10, 10, 0); add(0, 10, 1);
    for (i = 0; i < 65; i++) add($urandom, $urandom, i == 64);
    for (i = 0; i < 64; i++) add(i, (i % 2) ? -i * i : i * i, i == 63);
    sent = 26 + 65 + 64;
    while (vertex_q.size() != 0 || in_flight) @(posedge clk);
    // let everything drain with the sender held off
    hold_send = 1;
    while (tri_q.size() != 0) @(posedge clk);
    hold_send = 0;
    while (sent < 350) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) add($urandom, $urandom, i == n - 1);
        end
        1: begin
          n = $urandom_range(1, 2);
          for (i = 0; i < n; i++) add($urandom, $urandom, i == n - 1);
        end
        default: begin
          n = $urandom_range(3, 12);
          add_poly(n, $urandom_range(20, 30000), $urandom_range(0, 1) == 1);
        end
      endcase
      sent += n;
    end
    while (vertex_q.size() != 0 || in_flight || tri_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0 && tri_q.size() == 0)
      $display("tb_ear_clipping_triangulator_top OK");
    else
      $display("tb_ear_clipping_triangulator_top NOT OK");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb_ear_clipping_triangulator_top NOT OK");
    $finish;
  end
endmodule
